// ===== hw/rtl/multiclass_thread_scheduler_core_macros.svh =====
// Assertion macros shared by the scheduler checkers.
// Each macro expects clk and rst in scope.
`ifndef MULTICLASS_THREAD_SCHEDULER_CORE_MACROS_SVH
`define MULTICLASS_THREAD_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mts_pkg.sv =====
// Shared types, constants and helpers of the thread scheduler.
// No dependencies.
package mts_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int WEIGHT_BITS = 7;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int TOT_W       = WEIGHT_BITS + $clog2(NUM_SLOTS);
  localparam int RV_W        = 16;
  localparam int STAMP_W     = 32;
  localparam int WMAX        = (1 << WEIGHT_BITS) - 1;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_CHANGE = 3'd1;
  localparam logic [2:0] CMD_YIELD  = 3'd2;
  localparam logic [2:0] CMD_JOIN   = 3'd3;
  localparam logic [2:0] CMD_END    = 3'd4;

  localparam logic [1:0] CLS_RR   = 2'd0;
  localparam logic [1:0] CLS_LOT  = 2'd1;
  localparam logic [1:0] CLS_PRIO = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0]             cls;
    logic [WEIGHT_BITS-1:0] weight;
    logic [STAMP_W-1:0]     stamp;
    logic [IDX_W-1:0]       wait_tgt;
  } slot_rec_t;

  typedef struct packed {
    logic [RV_W-1:0]   random_value;
    logic signed [7:0] attr;
    logic [1:0]        sched_class;
    logic [3:0]        target_slot;
    logic [2:0]        command;
  } cmd_req_t;

  typedef struct packed {
    logic       switched;
    logic       run_valid;
    logic [3:0] run_slot;
    logic [3:0] new_slot;
    logic       status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_RMW_RD, S_RMW_WR, S_SCAN_RD, S_SCAN_EV, S_DIV_GO, S_DIV, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    SM_RR, SM_LOT_TOTAL, SM_LOT_WALK, SM_PRIO, SM_WAKE
  } scan_mode_t;

  typedef enum logic [1:0] {
    RK_CHG, RK_YIELD, RK_JOIN, RK_WAKE
  } rmw_kind_t;

  function automatic logic [WEIGHT_BITS-1:0] weight_for(input logic [1:0] cls,
                                                        input logic signed [7:0] attr);
    int a;
    a = int'(attr);
    if (cls == CLS_LOT) begin
      if (a < 1) a = 1;
    end else if (cls == CLS_PRIO) begin
      if (a < 0) a = 0;
    end else begin
      a = 0;
    end
    if (a > WMAX) a = WMAX;
    return WEIGHT_BITS'(a);
  endfunction

endpackage

// ===== hw/rtl/mts_ram.sv =====
// Single-port synchronous RAM, registered read, read-first.
// No dependencies.
module mts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/mts_div.sv =====
// Restoring remainder unit: one quotient bit per cycle.
// Depends on mts_pkg.
module mts_div import mts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RV_W-1:0]  dividend,
  input  logic [TOT_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] rem
);

  localparam int CNT_W = $clog2(RV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RV_W-1:0]  dvd;
  logic [TOT_W-1:0] dvs;
  logic [TOT_W:0]   trial;
  logic             ge;
  logic [TOT_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[RV_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? TOT_W'(trial - {1'b0, dvs}) : TOT_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(RV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

endmodule

// ===== hw/rtl/mts_seq.sv =====
// Command sequencer: slot flags, run state, table scans and read-modify-write.
// Depends on mts_pkg; drives the slot RAM and the remainder unit.
module mts_seq import mts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  cmd_req_t         req,
  output logic             req_ready,
  output logic             res_valid,
  output result_t          res,
  input  logic             res_ready,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_addr,
  output slot_rec_t        ram_wdata,
  input  slot_rec_t        ram_rdata,
  output logic             div_start,
  output logic [RV_W-1:0]  div_dividend,
  output logic [TOT_W-1:0] div_divisor,
  input  logic             div_done,
  input  logic [TOT_W-1:0] div_rem
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

  state_t st, st_next;
  logic [NUM_SLOTS-1:0] used, used_next, fin, fin_next, wt, wt_next;
  logic cur_valid, cur_valid_next;
  logic [IDX_W-1:0] cur_slot, cur_slot_next;
  logic [STAMP_W-1:0] cnt, cnt_next;

  logic [IDX_W-1:0] c_tgt, c_tgt_next;
  logic [1:0] c_cls, c_cls_next;
  logic [WEIGHT_BITS-1:0] c_wt, c_wt_next;
  logic [RV_W-1:0] c_rv, c_rv_next;
  logic status, status_next;
  logic [3:0] new_slot, new_slot_next;
  logic old_valid, old_valid_next;
  logic [IDX_W-1:0] old_slot, old_slot_next;
  rmw_kind_t rmw_kind, rmw_kind_next;
  logic [IDX_W-1:0] rmw_addr, rmw_addr_next;
  scan_mode_t scan_mode, scan_mode_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic single, single_next;
  logic found, found_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  logic [STAMP_W-1:0] best_stamp, best_stamp_next;
  logic [WEIGHT_BITS-1:0] best_w, best_w_next;
  logic [TOT_W-1:0] total, total_next, acc, acc_next, winner, winner_next, acc_sum;
  logic have_prev, have_prev_next;
  logic [IDX_W-1:0] prev_idx, prev_idx_next, first_idx, first_idx_next;
  logic [STAMP_W-1:0] prev_stamp, prev_stamp_next;

  logic go_scan, run_set, run_none;
  scan_mode_t go_mode;
  logic [IDX_W-1:0] run_idx, tix, free_idx;
  logic tgt_ok, rdy_s, rdy_r, bef_ib, bef_pi, hit;

  // scan compare for the entry whose read data is on the RAM output
  always_comb begin
    rdy_s  = used[scan_idx] & ~fin[scan_idx] & ~wt[scan_idx];
    rdy_r  = used[rmw_addr] & ~fin[rmw_addr] & ~wt[rmw_addr];
    bef_ib = (ram_rdata.stamp < best_stamp) ||
             (ram_rdata.stamp == best_stamp && scan_idx < best_idx);
    bef_pi = (prev_stamp < ram_rdata.stamp) ||
             (prev_stamp == ram_rdata.stamp && prev_idx < scan_idx);
    case (scan_mode)
      SM_RR:       hit = rdy_s && ram_rdata.cls == CLS_RR && (!found || bef_ib);
      SM_LOT_WALK: hit = rdy_s && ram_rdata.cls == CLS_LOT && (!have_prev || bef_pi) &&
                         (!found || bef_ib);
      SM_PRIO:     hit = rdy_s && ram_rdata.cls == CLS_PRIO &&
                         (!found || ram_rdata.weight > best_w ||
                          (ram_rdata.weight == best_w && bef_ib));
      SM_WAKE:     hit = used[scan_idx] && wt[scan_idx] && ram_rdata.wait_tgt == cur_slot &&
                         (!found || bef_ib);
      default:     hit = 1'b0;
    endcase
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) free_idx = IDX_W'(i);
    end
    tix    = IDX_W'(req.target_slot);
    tgt_ok = (8'(req.target_slot) < 8'(NUM_SLOTS)) && used[tix];
  end

  always_comb begin
    st_next = st; used_next = used; fin_next = fin; wt_next = wt;
    cur_valid_next = cur_valid; cur_slot_next = cur_slot; cnt_next = cnt;
    c_tgt_next = c_tgt; c_cls_next = c_cls; c_wt_next = c_wt;
    c_rv_next = c_rv; status_next = status; new_slot_next = new_slot;
    old_valid_next = old_valid; old_slot_next = old_slot;
    rmw_kind_next = rmw_kind; rmw_addr_next = rmw_addr;
    scan_mode_next = scan_mode; scan_idx_next = scan_idx; single_next = single;
    found_next = found; best_idx_next = best_idx; best_stamp_next = best_stamp;
    best_w_next = best_w; total_next = total; acc_next = acc; winner_next = winner;
    have_prev_next = have_prev; prev_idx_next = prev_idx; prev_stamp_next = prev_stamp;
    first_idx_next = first_idx;
    req_ready = (st == S_IDLE); res_valid = 1'b0;
    ram_we = 1'b0; ram_addr = scan_idx; ram_wdata = ram_rdata; div_start = 1'b0;
    go_scan = 1'b0; go_mode = scan_mode; run_set = 1'b0; run_none = 1'b0;
    run_idx = best_idx; acc_sum = '0;

    case (st)
      S_IDLE: begin
        if (req_valid) begin
          c_tgt_next = tix; c_cls_next = req.sched_class;
          c_wt_next = weight_for(req.sched_class, req.attr); c_rv_next = req.random_value;
          status_next = 1'b1; new_slot_next = '0;
          old_valid_next = cur_valid; old_slot_next = cur_slot;
          st_next = S_FIN;
          case (req.command)
            CMD_CREATE: begin
              if (req.sched_class != CLS_BAD && !(&used)) st_next = S_CREATE;
            end
            CMD_CHANGE: begin
              if (tgt_ok && req.sched_class != CLS_BAD && !(cur_valid && cur_slot == tix)) begin
                rmw_kind_next = RK_CHG; rmw_addr_next = tix; st_next = S_RMW_RD;
              end
            end
            CMD_YIELD: begin
              status_next = 1'b0;
              if (!cur_valid) begin
                single_next = 1'b0; go_scan = 1'b1; go_mode = SM_RR;
              end else begin
                rmw_kind_next = RK_YIELD; rmw_addr_next = cur_slot; st_next = S_RMW_RD;
              end
            end
            CMD_JOIN: begin
              if (cur_valid && tgt_ok && cur_slot != tix) begin
                status_next = 1'b0;
                if (!fin[tix]) begin
                  wt_next[cur_slot] = 1'b1;
                  rmw_kind_next = RK_JOIN; rmw_addr_next = cur_slot; st_next = S_RMW_RD;
                end
              end
            end
            CMD_END: begin
              if (cur_valid) begin
                status_next = 1'b0; fin_next[cur_slot] = 1'b1;
                go_scan = 1'b1; go_mode = SM_WAKE;
              end
            end
            default: st_next = S_FIN;
          endcase
        end
      end

      S_CREATE: begin
        ram_we = 1'b1; ram_addr = free_idx;
        ram_wdata.cls = c_cls; ram_wdata.weight = c_wt;
        ram_wdata.stamp = cnt; ram_wdata.wait_tgt = '0;
        used_next[free_idx] = 1'b1; fin_next[free_idx] = 1'b0; wt_next[free_idx] = 1'b0;
        cnt_next = cnt + 1'b1; new_slot_next = 4'(free_idx); status_next = 1'b0;
        st_next = S_FIN;
      end

      S_RMW_RD: begin
        ram_addr = rmw_addr; st_next = S_RMW_WR;
      end

      S_RMW_WR: begin
        ram_addr = rmw_addr; ram_we = 1'b1;
        case (rmw_kind)
          RK_CHG: begin
            ram_wdata.cls = c_cls; ram_wdata.weight = c_wt;
            if (rdy_r) begin
              ram_wdata.stamp = cnt; cnt_next = cnt + 1'b1;
            end
            status_next = 1'b0; st_next = S_FIN;
          end
          RK_YIELD: begin
            single_next = 1'b1; go_scan = 1'b1;
            case (ram_rdata.cls)
              CLS_RR: begin
                ram_wdata.stamp = cnt; cnt_next = cnt + 1'b1; go_mode = SM_RR;
              end
              CLS_LOT: go_mode = SM_LOT_TOTAL;
              default: go_mode = SM_PRIO;
            endcase
          end
          RK_JOIN: begin
            ram_wdata.stamp = cnt; ram_wdata.wait_tgt = c_tgt; cnt_next = cnt + 1'b1;
            single_next = 1'b0; go_scan = 1'b1; go_mode = SM_RR;
          end
          default: begin
            ram_wdata.stamp = cnt; cnt_next = cnt + 1'b1;
            go_scan = 1'b1; go_mode = SM_WAKE;
          end
        endcase
      end

      S_SCAN_RD: begin
        ram_addr = scan_idx; st_next = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (scan_mode == SM_LOT_TOTAL && rdy_s && ram_rdata.cls == CLS_LOT)
          total_next = total + TOT_W'(ram_rdata.weight);
        if (hit) begin
          found_next = 1'b1; best_idx_next = scan_idx;
          best_stamp_next = ram_rdata.stamp; best_w_next = ram_rdata.weight;
        end
        if (scan_idx != LAST) begin
          scan_idx_next = scan_idx + 1'b1; st_next = S_SCAN_RD;
        end else begin
          st_next = S_FIN;
          case (scan_mode)
            SM_RR: begin
              if (found_next) begin
                run_set = 1'b1; run_idx = best_idx_next;
              end else if (!single) begin
                go_scan = 1'b1; go_mode = SM_LOT_TOTAL;
              end
            end
            SM_LOT_TOTAL: begin
              if (total_next != '0) begin
                st_next = S_DIV_GO;
              end else if (!single) begin
                go_scan = 1'b1; go_mode = SM_PRIO;
              end
            end
            SM_LOT_WALK: begin
              if (!found_next) begin
                run_set = 1'b1; run_idx = first_idx;
              end else begin
                acc_sum = acc + TOT_W'(best_w_next);
                if (!have_prev) first_idx_next = best_idx_next;
                if (acc_sum >= winner) begin
                  run_set = 1'b1; run_idx = best_idx_next;
                end else begin
                  acc_next = acc_sum; have_prev_next = 1'b1;
                  prev_idx_next = best_idx_next; prev_stamp_next = best_stamp_next;
                  go_scan = 1'b1; go_mode = SM_LOT_WALK;
                end
              end
            end
            SM_PRIO: begin
              if (found_next) begin
                run_set = 1'b1; run_idx = best_idx_next;
              end else if (!single) begin
                run_none = 1'b1;
              end
            end
            SM_WAKE: begin
              if (found_next) begin
                wt_next[best_idx_next] = 1'b0;
                rmw_kind_next = RK_WAKE; rmw_addr_next = best_idx_next; st_next = S_RMW_RD;
              end else begin
                single_next = 1'b0; go_scan = 1'b1; go_mode = SM_RR;
              end
            end
            default: st_next = S_FIN;
          endcase
        end
      end

      S_DIV_GO: begin
        div_start = 1'b1; st_next = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          winner_next = div_rem + 1'b1; acc_next = '0; have_prev_next = 1'b0;
          go_scan = 1'b1; go_mode = SM_LOT_WALK;
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) st_next = S_IDLE;
      end

      default: st_next = S_IDLE;
    endcase

    if (go_scan) begin
      scan_mode_next = go_mode; scan_idx_next = '0; found_next = 1'b0; st_next = S_SCAN_RD;
      if (go_mode == SM_LOT_TOTAL) total_next = '0;
    end
    if (run_set) begin
      cur_valid_next = 1'b1; cur_slot_next = run_idx;
    end
    if (run_none) begin
      cur_valid_next = 1'b0; cur_slot_next = '0;
    end
  end

  always_comb begin
    res.status    = status;
    res.new_slot  = new_slot;
    res.run_slot  = cur_valid ? 4'(cur_slot) : 4'd0;
    res.run_valid = cur_valid;
    res.switched  = (old_valid != cur_valid) || (cur_valid && old_slot != cur_slot);
    div_dividend  = c_rv;
    div_divisor   = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; used <= '0; fin <= '0; wt <= '0;
      cur_valid <= 1'b0; cur_slot <= '0; cnt <= '0;
    end else begin
      st <= st_next; used <= used_next; fin <= fin_next; wt <= wt_next;
      cur_valid <= cur_valid_next; cur_slot <= cur_slot_next; cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    c_tgt <= c_tgt_next; c_cls <= c_cls_next; c_wt <= c_wt_next;
    c_rv <= c_rv_next; status <= status_next; new_slot <= new_slot_next;
    old_valid <= old_valid_next; old_slot <= old_slot_next;
    rmw_kind <= rmw_kind_next; rmw_addr <= rmw_addr_next;
    scan_mode <= scan_mode_next; scan_idx <= scan_idx_next; single <= single_next;
    found <= found_next; best_idx <= best_idx_next; best_stamp <= best_stamp_next;
    best_w <= best_w_next; total <= total_next; acc <= acc_next; winner <= winner_next;
    have_prev <= have_prev_next; prev_idx <= prev_idx_next; prev_stamp <= prev_stamp_next;
    first_idx <= first_idx_next;
  end

endmodule

// ===== hw/rtl/multiclass_thread_scheduler_core.sv =====
// Multiclass thread scheduler, top level.
// Depends on mts_pkg, mts_ram, mts_div and mts_seq.
//
// Usage:
//  - Input stream (s_*): one command request per handshake. s_tready is high only
//    while the sequencer is idle; one command is worked on at a time.
//  - Output stream (m_*): exactly one result per command, held in an output
//    register until m_tready; the sequencer waits at its final step while that
//    register is full and not being drained, and can take the next request as
//    soon as its result is loaded.
//  - Work per command: create writes the lowest free slot; change class reads
//    the slot record and writes it back. Every table pass does one RAM read
//    and one compare per slot on the single RAM port. Dispatch runs up to
//    three passes (round robin, lottery total, priority); lottery adds a
//    remainder step plus one pass per slot walked in stamp order; end adds
//    one pass, plus one more pass per woken joiner. The longest command is
//    an end that wakes 15 lottery joiners.
//  - Reset (rst, synchronous): clears the used, finished and waiting flags, the
//    running slot and the stamp counter. No RAM clearing pass is needed.
module multiclass_thread_scheduler_core import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], target_slot[6:3], sched_class[8:7], attr[16:9],
  // random_value[32:17], zero fill [39:33]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], new_slot[4:1], run_slot[8:5], run_valid[9], switched[10],
  // zero fill [15:11]
  output logic [15:0] m_tdata
);

  cmd_req_t         req;
  result_t          res;
  logic             res_valid, res_ready;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  slot_rec_t        ram_wdata, ram_rdata;
  logic             div_start, div_done;
  logic [RV_W-1:0]  div_dividend;
  logic [TOT_W-1:0] div_divisor, div_rem;
  result_t          out_res;

  assign req       = cmd_req_t'(s_tdata[32:0]);
  assign res_ready = !m_tvalid || m_tready;

  mts_seq u_seq (
    .clk, .rst,
    .req_valid (s_tvalid), .req, .req_ready (s_tready),
    .res_valid, .res, .res_ready,
    .ram_we, .ram_addr, .ram_wdata, .ram_rdata,
    .div_start, .div_dividend, .div_divisor, .div_done, .div_rem
  );

  mts_ram #(.DEPTH(NUM_SLOTS), .WIDTH($bits(slot_rec_t))) u_ram (
    .clk, .we (ram_we), .addr (ram_addr), .wdata (ram_wdata), .rdata (ram_rdata)
  );

  mts_div u_div (
    .clk, .rst, .start (div_start), .dividend (div_dividend), .divisor (div_divisor),
    .done (div_done), .rem (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res <= res;
  end

  assign m_tdata = {5'd0, out_res};

endmodule

// ===== hw/rtl/mts_checker.sv =====
// Port-level checks for the thread scheduler, bound to the top level.
// Depends on multiclass_thread_scheduler_core_macros.svh.
`include "multiclass_thread_scheduler_core_macros.svh"

module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  `MTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `MTS_ASSERT_NOW(a_idle_slot, m_tvalid && !m_tdata[9], m_tdata[8:5] == 4'd0, "run_slot set with nothing running")
  `MTS_ASSERT_NOW(a_reject_quiet, m_tvalid && m_tdata[0], !m_tdata[10] && m_tdata[4:1] == 4'd0, "rejected request had effects")
  `MTS_ASSERT_NEXT(a_one_at_time, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

bind multiclass_thread_scheduler_core mts_checker u_mts_checker (.*);
